FILE: src/integer_to_roman_numeral_encoder_core_defines.svh
// Assertion macros for the Roman numeral encoder core.
`ifndef INTEGER_TO_ROMAN_NUMERAL_ENCODER_CORE_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_ENCODER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define RNE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rne assertion failed");
// Check a property on every clock edge, reset included.
`define RNE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("rne assertion failed");
`else
`define RNE_ASSERT(lbl, prop)
`define RNE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: src/rne_pkg.sv
// Shared types and constants of the Roman numeral encoder.
`timescale 1ns / 1ps
package rne_pkg;

	localparam int VALUE_W  = 12;
	localparam int AMT_W    = 10;
	localparam int LETTER_W = 7;
	localparam int PC_W     = 5;

	// Microcode operations
	localparam logic [1:0] OP_SKIP_LT  = 2'd0; // jump to target when rem < amt
	localparam logic [1:0] OP_EMIT     = 2'd1; // emit letter, go to next step
	localparam logic [1:0] OP_EMIT_SUB = 2'd2; // emit letter, rem -= amt, jump
	localparam logic [1:0] OP_NOP      = 2'd3; // go to next step

	// ASCII letters
	localparam logic [LETTER_W-1:0] LTR_I = 7'd73;
	localparam logic [LETTER_W-1:0] LTR_V = 7'd86;
	localparam logic [LETTER_W-1:0] LTR_X = 7'd88;
	localparam logic [LETTER_W-1:0] LTR_L = 7'd76;
	localparam logic [LETTER_W-1:0] LTR_C = 7'd67;
	localparam logic [LETTER_W-1:0] LTR_D = 7'd68;
	localparam logic [LETTER_W-1:0] LTR_M = 7'd77;

	typedef struct packed {
		logic [1:0]          op;
		logic [LETTER_W-1:0] letter;
		logic [AMT_W-1:0]    amt;
		logic [PC_W-1:0]     tgt;
	} ucode_t;

	typedef struct packed {
		logic               load;
		logic               sub;
		logic [VALUE_W-1:0] load_val;
		logic [AMT_W-1:0]   amt;
	} dp_ctrl_t;

	typedef struct packed {
		logic ge;         // rem >= amt
		logic zero_after; // rem - amt == 0
		logic rem_zero;   // rem == 0
	} dp_stat_t;

endpackage

FILE: src/rne_ucode_rom.sv
// Microcode table: greedy Roman numeral program, one control word per step.
`timescale 1ns / 1ps
module rne_ucode_rom (
	input  logic [rne_pkg::PC_W-1:0] pc,
	output rne_pkg::ucode_t          word
);
	import rne_pkg::*;

	function automatic ucode_t mk(input logic [1:0] op, input logic [LETTER_W-1:0] letter,
			input logic [AMT_W-1:0] amt, input logic [PC_W-1:0] tgt);
		ucode_t w;
		w.op     = op;
		w.letter = letter;
		w.amt    = amt;
		w.tgt    = tgt;
		return w;
	endfunction

	// Decode the step into its control word
	always_comb begin
		unique case (pc)
			5'd0:    word = mk(OP_SKIP_LT,  LTR_M, 10'd1000, 5'd2);
			5'd1:    word = mk(OP_EMIT_SUB, LTR_M, 10'd1000, 5'd0);
			5'd2:    word = mk(OP_SKIP_LT,  LTR_C, 10'd900,  5'd5);
			5'd3:    word = mk(OP_EMIT,     LTR_C, 10'd900,  5'd4);
			5'd4:    word = mk(OP_EMIT_SUB, LTR_M, 10'd900,  5'd5);
			5'd5:    word = mk(OP_SKIP_LT,  LTR_D, 10'd500,  5'd7);
			5'd6:    word = mk(OP_EMIT_SUB, LTR_D, 10'd500,  5'd7);
			5'd7:    word = mk(OP_SKIP_LT,  LTR_C, 10'd400,  5'd10);
			5'd8:    word = mk(OP_EMIT,     LTR_C, 10'd400,  5'd9);
			5'd9:    word = mk(OP_EMIT_SUB, LTR_D, 10'd400,  5'd10);
			5'd10:   word = mk(OP_SKIP_LT,  LTR_C, 10'd100,  5'd12);
			5'd11:   word = mk(OP_EMIT_SUB, LTR_C, 10'd100,  5'd10);
			5'd12:   word = mk(OP_SKIP_LT,  LTR_X, 10'd90,   5'd15);
			5'd13:   word = mk(OP_EMIT,     LTR_X, 10'd90,   5'd14);
			5'd14:   word = mk(OP_EMIT_SUB, LTR_C, 10'd90,   5'd15);
			5'd15:   word = mk(OP_SKIP_LT,  LTR_L, 10'd50,   5'd17);
			5'd16:   word = mk(OP_EMIT_SUB, LTR_L, 10'd50,   5'd17);
			5'd17:   word = mk(OP_SKIP_LT,  LTR_X, 10'd40,   5'd20);
			5'd18:   word = mk(OP_EMIT,     LTR_X, 10'd40,   5'd19);
			5'd19:   word = mk(OP_EMIT_SUB, LTR_L, 10'd40,   5'd20);
			5'd20:   word = mk(OP_SKIP_LT,  LTR_X, 10'd10,   5'd22);
			5'd21:   word = mk(OP_EMIT_SUB, LTR_X, 10'd10,   5'd20);
			5'd22:   word = mk(OP_SKIP_LT,  LTR_I, 10'd9,    5'd25);
			5'd23:   word = mk(OP_EMIT,     LTR_I, 10'd9,    5'd24);
			5'd24:   word = mk(OP_EMIT_SUB, LTR_X, 10'd9,    5'd25);
			5'd25:   word = mk(OP_SKIP_LT,  LTR_V, 10'd5,    5'd27);
			5'd26:   word = mk(OP_EMIT_SUB, LTR_V, 10'd5,    5'd27);
			5'd27:   word = mk(OP_SKIP_LT,  LTR_I, 10'd4,    5'd30);
			5'd28:   word = mk(OP_EMIT,     LTR_I, 10'd4,    5'd29);
			5'd29:   word = mk(OP_EMIT_SUB, LTR_V, 10'd4,    5'd30);
			5'd30:   word = mk(OP_NOP,      LTR_I, 10'd1,    5'd31);
			default: word = mk(OP_EMIT_SUB, LTR_I, 10'd1,    5'd31);
		endcase
	end

endmodule

FILE: src/rne_datapath.sv
// Remainder register with its subtract and compare unit.
`timescale 1ns / 1ps
module rne_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  rne_pkg::dp_ctrl_t ctrl,
	output rne_pkg::dp_stat_t stat
);
	import rne_pkg::*;

	logic [VALUE_W-1:0] rem_q;
	logic [VALUE_W-1:0] amt_ext;
	logic [VALUE_W-1:0] diff;

	// Compare and subtract the step amount
	assign amt_ext = {{(VALUE_W-AMT_W){1'b0}}, ctrl.amt};
	assign diff    = rem_q - amt_ext;

	assign stat.ge         = (rem_q >= amt_ext);
	assign stat.zero_after = (diff == '0);
	assign stat.rem_zero   = (rem_q == '0);

	// Load a new value or take the amount off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctrl.load) begin
			rem_q <= ctrl.load_val;
		end else if (ctrl.sub) begin
			rem_q <= diff;
		end
	end

endmodule

FILE: src/integer_to_roman_numeral_encoder_core.sv
// Top level: microcoded Roman numeral encoder with stream ports.
//
// Usage:
//   Slave stream s_* carries one value per beat in s_tdata[11:0]; the
//   master stream m_* returns its numeral as one ASCII letter per beat,
//   most significant first, with m_tlast on the final letter.
//   A value of 0 is taken and produces no beat at all.
// Timing:
//   A step counter walks a 32-word microcode table, one step per cycle
//   unless a letter step waits on the output. Each letter has a step of
//   its own, as have each denomination test and the step before the ones
//   loop. The first letter is loaded once every larger denomination has
//   been tested; a nonzero value holds the block until its final letter.
//   s_tready rises again the cycle after the final letter is loaded into
//   the output register, so the next value is taken while it still waits.
// Reset and stall:
//   arst_n clears the sequencer and the output valid; no value is kept.
//   While m_tready is low the output register holds its beat and the
//   sequencer waits on its next letter step.
`timescale 1ns / 1ps
`include "integer_to_roman_numeral_encoder_core_defines.svh"
module integer_to_roman_numeral_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [11:0] value, [15:12] unused
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [6:0] letter, [7] zero
	output logic        m_tlast
);
	import rne_pkg::*;

	logic [PC_W-1:0]     pc_q;
	logic [PC_W-1:0]     pc_next;
	logic                busy_q;
	logic                m_tvalid_q;
	logic [LETTER_W-1:0] letter_q;
	logic                last_q;
	ucode_t              word;
	dp_ctrl_t            dp_ctrl;
	dp_stat_t            dp_stat;
	logic                s_fire;
	logic                out_free;
	logic                is_emit;
	logic                advance;
	logic                emit_fire;
	logic                done;

	rne_ucode_rom u_rom (
		.pc   (pc_q),
		.word (word)
	);

	rne_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (dp_ctrl),
		.stat   (dp_stat)
	);

	// Handshake and step qualification
	assign s_tready  = !busy_q;
	assign s_fire    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign is_emit   = (word.op == OP_EMIT) || (word.op == OP_EMIT_SUB);
	assign advance   = busy_q && (!is_emit || out_free);
	assign emit_fire = advance && is_emit;
	assign done      = advance && (word.op == OP_EMIT_SUB) && dp_stat.zero_after;

	// Drive the datapath
	always_comb begin
		dp_ctrl.load     = s_fire;
		dp_ctrl.load_val = s_tdata[VALUE_W-1:0];
		dp_ctrl.sub      = advance && (word.op == OP_EMIT_SUB);
		dp_ctrl.amt      = word.amt;
	end

	// Pick the next step
	always_comb begin
		unique case (word.op)
			OP_SKIP_LT:  pc_next = dp_stat.ge ? pc_q + {{(PC_W-1){1'b0}}, 1'b1} : word.tgt;
			OP_EMIT_SUB: pc_next = word.tgt;
			default:     pc_next = pc_q + {{(PC_W-1){1'b0}}, 1'b1};
		endcase
	end

	// Advance the sequencer and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_fire) begin
				pc_q   <= '0;
				busy_q <= (s_tdata[VALUE_W-1:0] != '0);
			end else if (advance) begin
				pc_q <= pc_next;
				if (done) begin
					busy_q <= 1'b0;
				end
			end
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Load the output beat
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			letter_q <= word.letter;
			last_q   <= done;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, letter_q};
	assign m_tlast  = last_q;

	// A nonzero value starts a run and blocks intake
	`RNE_ASSERT(a_start_busy, s_tvalid && s_tready && (s_tdata[11:0] != 12'd0) |=> !s_tready)
	// A zero value leaves the block free
	`RNE_ASSERT(a_zero_free, s_tvalid && s_tready && (s_tdata[11:0] == 12'd0) |=> s_tready)
	// A running conversion always has letters left to emit
	`RNE_ASSERT(a_busy_rem, busy_q |-> !dp_stat.rem_zero)
	// The final letter of a run frees the block in the next cycle
	`RNE_ASSERT_ALWAYS(a_done_free, arst_n && done |=> !busy_q || !arst_n)

endmodule
